// File: design/sfps_pkg.sv
// Shared constants, types and elaboration-time helpers for the structure-factor phase sum.
// Used by every module of the block but sfps_ram; depends on nothing else.
package sfps_pkg;

	// default sizes of the block
	localparam int MAX_ATOMS_DEF       = 256;
	localparam int PHASE_BITS_DEF      = 12;
	localparam int COORD_FRAC_BITS_DEF = 24;

	// fixed field widths
	localparam int COORD_W = 32;
	localparam int SLOT_W  = 8;
	localparam int OUT_W   = 26;
	localparam int TRIG_W  = 17;
	localparam int CNT_W   = 9;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// saturation bound of each sum, Q9.16
	localparam int SUM_LIMIT = 16777216;

	// register index, taken from paddr[2]
	localparam logic REG_ATOM_COUNT = 1'b0;

	// commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// 2*pi in Q60
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		COMP_X,
		COMP_Y,
		COMP_Z
	} comp_t;

	// one table entry: cosine and sine magnitudes of the first quadrant, Q1.16
	typedef struct packed {
		logic [TRIG_W-1:0] cos_v;
		logic [TRIG_W-1:0] sin_v;
	} trig_t;

	// (a * b) >> 60, a and b below 2^62
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = 128'(a) * 128'(b);
		return prod[123:60];
	endfunction

	// restoring long division, only run at elaboration
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// round a Q60 value to Q1.16, negative values clamp to zero
	function automatic logic [TRIG_W-1:0] q60_to_q16(input logic signed [63:0] v);
		logic [63:0] r;
		if (v < 0) begin
			r = '0;
		end else begin
			r = (64'(v) + (64'd1 << 43)) >> 44;
		end
		return r[TRIG_W-1:0];
	endfunction

	// Taylor series entry k of a table of 2^phase_bits steps per turn
	function automatic trig_t sincos_entry(input int k, input int phase_bits);
		logic [63:0]        step;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        t;
		logic signed [63:0] acc;
		trig_t              e;
		step = TWO_PI_Q60 >> phase_bits;
		x    = step * 64'(k);
		x2   = mul_q60(x, x);
		// sine
		t   = x;
		acc = $signed(x);
		for (int n = 1; n < 40; n++) begin
			if (t != 0) begin
				t   = div_u64(mul_q60(t, x2), 64'((2 * n) * (2 * n + 1)));
				acc = n[0] ? acc - $signed(t) : acc + $signed(t);
			end
		end
		e.sin_v = q60_to_q16(acc);
		// cosine
		t   = 64'd1 << 60;
		acc = $signed(64'd1 << 60);
		for (int n = 1; n < 40; n++) begin
			if (t != 0) begin
				t   = div_u64(mul_q60(t, x2), 64'((2 * n - 1) * (2 * n)));
				acc = n[0] ? acc - $signed(t) : acc + $signed(t);
			end
		end
		e.cos_v = q60_to_q16(acc);
		return e;
	endfunction

endpackage

// File: design/sfps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sfps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/sfps_trig_rom.sv
// First-quadrant cosine/sine table, built at elaboration, with registered read.
// Depends on sfps_pkg (entry type and table generator).
module sfps_trig_rom #(
	parameter int PHASE_BITS = sfps_pkg::PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic [PHASE_BITS-3:0] addr,
	output sfps_pkg::trig_t       entry
);

	localparam int DEPTH = 1 << (PHASE_BITS - 2);

	sfps_pkg::trig_t rom_w [DEPTH];
	sfps_pkg::trig_t entry_q;

	// fill the table from the rounded series
	for (genvar k = 0; k < DEPTH; k++) begin : g_rom
		localparam sfps_pkg::trig_t ENTRY = sfps_pkg::sincos_entry(k, PHASE_BITS);
		assign rom_w[k] = ENTRY;
	end

	// register the looked-up word
	always_ff @(posedge clk) begin
		entry_q <= rom_w[addr];
	end

	assign entry = entry_q;

endmodule

// File: design/structure_factor_phase_sum.sv
// Top level of the structure-factor phase sum: sequencer, shared multiplier, accumulators.
// Depends on sfps_pkg, sfps_ram and sfps_trig_rom.
//
// Use: the input channel carries load words (cmd 0) and query words (cmd 1).
// A load writes pos_x/y/z into slot atom_slot of the atom store in the cycle it
// is accepted and gives no result; the next word can follow at once.
// A query latches gvec_x/y/z and walks atoms 0 .. min(atom_count, MAX_ATOMS)-1.
// One signed 32x32 multiplier is shared over the three components, so each atom
// takes one multiplier pass per component, x then y then z. in_stall stays high
// for the whole query and until the result has been placed in the output register.
// The output register holds the word (sf_real, sf_imag) until it is taken; a
// stalled output holds its word, and while it waits the block still takes loads
// and a further query, which stops only before writing its own result.
// The user must write atom_count over the APB-style port only while the block is idle;
// the block itself does not enforce this. Reset clears the sequencer, pipeline valids and
// atom_count; the atom store is not cleared and must be loaded before it is summed.
module structure_factor_phase_sum #(
	parameter int MAX_ATOMS       = sfps_pkg::MAX_ATOMS_DEF,
	parameter int PHASE_BITS      = sfps_pkg::PHASE_BITS_DEF,
	parameter int COORD_FRAC_BITS = sfps_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  cmd,
	input  logic [sfps_pkg::SLOT_W-1:0]           atom_slot,
	input  logic signed [sfps_pkg::COORD_W-1:0]   pos_x,
	input  logic signed [sfps_pkg::COORD_W-1:0]   pos_y,
	input  logic signed [sfps_pkg::COORD_W-1:0]   pos_z,
	input  logic signed [sfps_pkg::COORD_W-1:0]   gvec_x,
	input  logic signed [sfps_pkg::COORD_W-1:0]   gvec_y,
	input  logic signed [sfps_pkg::COORD_W-1:0]   gvec_z,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [sfps_pkg::OUT_W-1:0]     sf_real,
	output logic signed [sfps_pkg::OUT_W-1:0]     sf_imag,
	// configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [sfps_pkg::PADDR_W-1:0]          paddr,
	input  logic [sfps_pkg::PDATA_W-1:0]          pwdata,
	output logic [sfps_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready
);

	localparam int AW       = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int CW       = $clog2(MAX_ATOMS + 1);
	localparam int NW       = (CW > sfps_pkg::CNT_W) ? CW : sfps_pkg::CNT_W;
	localparam int ACC_W    = (CW + 18 > 27) ? CW + 18 : 27;
	localparam int PH_SHIFT = 2 * COORD_FRAC_BITS - PHASE_BITS;
	localparam int CW3      = 3 * sfps_pkg::COORD_W;
	localparam int RW       = PHASE_BITS - 2;

	// configuration register
	logic [sfps_pkg::CNT_W-1:0] atom_count_q;
	logic                       cfg_wr;

	// sequencer
	sfps_pkg::state_t state_q, state_d;
	sfps_pkg::comp_t  comp_q;
	logic [AW-1:0]    atom_q;
	logic [CW-1:0]    last_idx_q;
	logic             issue;
	logic             last_issue;
	logic             load_out;
	logic             acc_clear;

	// input decode
	logic                  in_acc;
	logic                  query_acc;
	logic                  load_acc;
	logic [NW-1:0]         cnt_ext;
	logic [NW-1:0]         n_eff;
	logic [31:0]           slot_ext;
	logic                  slot_ok;
	logic [CW3-1:0]        ram_rdata;

	// vector held for the query
	logic signed [sfps_pkg::COORD_W-1:0] gx_q, gy_q, gz_q;

	// pipeline
	logic                                v_s1, v_s2, v_s3, v_s4;
	logic                                last_s1, last_s2, last_s3, last_s4;
	sfps_pkg::comp_t                     comp_s1, comp_s2;
	logic signed [sfps_pkg::COORD_W-1:0] g_sel, r_sel;
	logic signed [63:0]                  prod_s2;
	logic [63:0]                         dot_q;
	logic [63:0]                         dot_sum;
	logic [PHASE_BITS-1:0]               phase_s3;
	logic [1:0]                          quad_s4;
	sfps_pkg::trig_t                     trig_s4;

	// accumulators
	logic signed [ACC_W-1:0] re_q, im_q;
	logic signed [ACC_W-1:0] c_ext, s_ext;
	logic signed [ACC_W-1:0] re_add, im_add;
	logic signed [ACC_W-1:0] re_sat, im_sat;
	logic signed [ACC_W-1:0] lim_pos, lim_neg;

	// output register
	logic                                out_valid_q;
	logic signed [sfps_pkg::OUT_W-1:0]   sf_real_q, sf_imag_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == sfps_pkg::REG_ATOM_COUNT);
	assign prdata = (paddr[2] == sfps_pkg::REG_ATOM_COUNT)
		? sfps_pkg::PDATA_W'(atom_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q <= '0;
		end else if (cfg_wr) begin
			atom_count_q <= pwdata[sfps_pkg::CNT_W-1:0];
		end
	end

	// input handshake and decode
	assign in_acc    = in_valid && !in_stall;
	assign query_acc = in_acc && (cmd == sfps_pkg::CMD_QUERY);
	assign load_acc  = in_acc && (cmd == sfps_pkg::CMD_LOAD);
	assign slot_ext  = 32'(atom_slot);
	assign slot_ok   = slot_ext < 32'(MAX_ATOMS);
	assign cnt_ext   = NW'(atom_count_q);
	assign n_eff     = (cnt_ext > NW'(MAX_ATOMS)) ? NW'(MAX_ATOMS) : cnt_ext;

	// atom store: x, y, z side by side
	sfps_ram #(
		.WIDTH (CW3),
		.DEPTH (MAX_ATOMS)
	) u_store (
		.clk   (clk),
		.we    (load_acc && slot_ok),
		.waddr (slot_ext[AW-1:0]),
		.wdata ({pos_z, pos_y, pos_x}),
		.raddr (atom_q),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfps_pkg::ST_IDLE: begin
				if (query_acc) begin
					state_d = (n_eff == '0) ? sfps_pkg::ST_FINISH : sfps_pkg::ST_RUN;
				end
			end
			sfps_pkg::ST_RUN: begin
				if (last_issue) begin
					state_d = sfps_pkg::ST_DRAIN;
				end
			end
			sfps_pkg::ST_DRAIN: begin
				if (v_s4 && last_s4) begin
					state_d = sfps_pkg::ST_FINISH;
				end
			end
			sfps_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = sfps_pkg::ST_IDLE;
				end
			end
			default: state_d = sfps_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs; the input is open only when idle
	always_comb begin
		in_stall  = 1'b1;
		issue     = 1'b0;
		load_out  = 1'b0;
		acc_clear = 1'b0;
		unique case (state_q)
			sfps_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				acc_clear = in_valid && (cmd == sfps_pkg::CMD_QUERY);
			end
			sfps_pkg::ST_RUN: begin
				issue = 1'b1;
			end
			sfps_pkg::ST_DRAIN: begin
				issue = 1'b0;
			end
			sfps_pkg::ST_FINISH: begin
				load_out = !out_valid_q || !out_stall;
			end
			default: in_stall = 1'b1;
		endcase
	end

	assign last_issue = issue && (comp_q == sfps_pkg::COMP_Z)
		&& (CW'(atom_q) == last_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// step atom and component counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q <= sfps_pkg::COMP_X;
			atom_q <= '0;
		end else if (query_acc) begin
			comp_q <= sfps_pkg::COMP_X;
			atom_q <= '0;
		end else if (issue) begin
			if (comp_q == sfps_pkg::COMP_Z) begin
				comp_q <= sfps_pkg::COMP_X;
				atom_q <= atom_q + 1'b1;
			end else begin
				comp_q <= sfps_pkg::comp_t'(comp_q + 2'd1);
			end
		end
	end

	// hold the query vector and the last atom index
	always_ff @(posedge clk) begin
		if (query_acc) begin
			gx_q       <= gvec_x;
			gy_q       <= gvec_y;
			gz_q       <= gvec_z;
			last_idx_q <= CW'(n_eff - NW'(1));
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (comp_s2 == sfps_pkg::COMP_Z);
			v_s4 <= v_s3;
		end
	end

	// stage 1: pick one coordinate pair for the shared multiplier
	always_comb begin
		case (comp_s1)
			sfps_pkg::COMP_X: begin
				g_sel = gx_q;
				r_sel = $signed(ram_rdata[0 +: sfps_pkg::COORD_W]);
			end
			sfps_pkg::COMP_Y: begin
				g_sel = gy_q;
				r_sel = $signed(ram_rdata[sfps_pkg::COORD_W +: sfps_pkg::COORD_W]);
			end
			default: begin
				g_sel = gz_q;
				r_sel = $signed(ram_rdata[2 * sfps_pkg::COORD_W +: sfps_pkg::COORD_W]);
			end
		endcase
	end

	// stage 2 adds into the dot product; the third term gives the phase
	assign dot_sum = dot_q + 64'(prod_s2);

	always_ff @(posedge clk) begin
		comp_s1 <= comp_q;
		last_s1 <= last_issue;
		prod_s2 <= 64'(g_sel) * 64'(r_sel);
		comp_s2 <= comp_s1;
		last_s2 <= last_s1;
		if (v_s2) begin
			dot_q <= (comp_s2 == sfps_pkg::COMP_X) ? 64'(prod_s2) : dot_sum;
		end
		phase_s3 <= dot_sum[PH_SHIFT +: PHASE_BITS];
		last_s3  <= last_s2;
		quad_s4  <= phase_s3[PHASE_BITS-1 -: 2];
		last_s4  <= last_s3;
	end

	// stage 3: table lookup
	sfps_trig_rom #(
		.PHASE_BITS (PHASE_BITS)
	) u_rom (
		.clk   (clk),
		.addr  (phase_s3[RW-1:0]),
		.entry (trig_s4)
	);

	// stage 4: fold the quadrant into signed terms
	assign c_ext = $signed(ACC_W'(trig_s4.cos_v));
	assign s_ext = $signed(ACC_W'(trig_s4.sin_v));

	always_comb begin
		case (quad_s4)
			2'd0: begin
				re_add = c_ext;
				im_add = -s_ext;
			end
			2'd1: begin
				re_add = -s_ext;
				im_add = -c_ext;
			end
			2'd2: begin
				re_add = -c_ext;
				im_add = s_ext;
			end
			default: begin
				re_add = s_ext;
				im_add = c_ext;
			end
		endcase
	end

	// accumulate
	always_ff @(posedge clk) begin
		if (acc_clear) begin
			re_q <= '0;
			im_q <= '0;
		end else if (v_s4) begin
			re_q <= re_q + re_add;
			im_q <= im_q + im_add;
		end
	end

	// saturate to the output range
	assign lim_pos = $signed(ACC_W'(sfps_pkg::SUM_LIMIT));
	assign lim_neg = -lim_pos;
	assign re_sat  = (re_q > lim_pos) ? lim_pos : ((re_q < lim_neg) ? lim_neg : re_q);
	assign im_sat  = (im_q > lim_pos) ? lim_pos : ((im_q < lim_neg) ? lim_neg : im_q);

	// output register: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sf_real_q <= sfps_pkg::OUT_W'(re_sat);
			sf_imag_q <= sfps_pkg::OUT_W'(im_sat);
		end
	end

	assign out_valid = out_valid_q;
	assign sf_real   = sf_real_q;
	assign sf_imag   = sf_imag_q;

endmodule

// File: design/sfps_checker.sv
// Port-level checker for structure_factor_phase_sum, with its bind.
// Depends on sfps_pkg; attaches to the top level.
module sfps_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                cmd,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [sfps_pkg::OUT_W-1:0]   sf_real,
	input logic signed [sfps_pkg::OUT_W-1:0]   sf_imag
);

	// a query holds the input side off in the following cycle
	a_query_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (cmd == sfps_pkg::CMD_QUERY)) |=> in_stall)
		else $error("input taken directly after a query word");

	// a load leaves the block ready for the next word
	a_load_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (cmd == sfps_pkg::CMD_LOAD)) |=> !in_stall)
		else $error("load word stalled the input");

	// results stay inside the saturation bounds
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((sf_real <= 26'sd16777216) && (sf_real >= -26'sd16777216)
			&& (sf_imag <= 26'sd16777216) && (sf_imag >= -26'sd16777216)))
		else $error("result outside saturation range");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(sf_real) && $stable(sf_imag)))
		else $error("stalled result word changed");

endmodule

bind structure_factor_phase_sum sfps_checker u_sfps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.cmd       (cmd),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.sf_real   (sf_real),
	.sf_imag   (sf_imag)
);

// File: sim/testbench.sv
// Self-checking testbench for structure_factor_phase_sum: atom loads, phase-sum queries,
// atom_count writes over the APB-style port, with random idling on both channels.
// Depends on sfps_pkg and the block's RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfps_pkg::*;

	localparam int N_SLOTS      = MAX_ATOMS_DEF;
	localparam int PH_BITS      = PHASE_BITS_DEF;
	localparam int FRAC_BITS    = COORD_FRAC_BITS_DEF;
	localparam int QUARTER      = 1 << (PH_BITS - 2);
	localparam int PH_SHIFT     = 2 * FRAC_BITS - PH_BITS;
	localparam int RANDOM_ITEMS = 1700;
	localparam int HOLD_CYCLES  = 1500;
	localparam int IDLE_LIMIT   = 20000;
	localparam int LOAD_SETTLE  = 8;
	localparam int FINAL_SETTLE = 40;

	// handy Q8.24 coordinates
	localparam logic signed [COORD_W-1:0] ONE  = 32'sh0100_0000;
	localparam logic signed [COORD_W-1:0] HALF = 32'sh0080_0000;
	localparam logic signed [COORD_W-1:0] MAXC = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] MINC = 32'h8000_0000;
	localparam logic signed [COORD_W-1:0] NEG1 = 32'hFF00_0000;

	typedef struct {
		logic                      cmd;
		logic [SLOT_W-1:0]         slot;
		logic signed [COORD_W-1:0] px, py, pz;
		logic signed [COORD_W-1:0] gx, gy, gz;
	} in_word_t;

	typedef struct {
		logic signed [OUT_W-1:0] re;
		logic signed [OUT_W-1:0] im;
	} sf_word_t;

	typedef struct {
		int       count;
		in_word_t w;
		bit       typed;
		int       want_re;
		int       want_im;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_stall, cmd;
	logic [SLOT_W-1:0] atom_slot;
	logic signed [COORD_W-1:0] pos_x, pos_y, pos_z, gvec_x, gvec_y, gvec_z;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] sf_real, sf_imag;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;

	// predictor state: atom store, register copy, first-quadrant table
	logic signed [COORD_W-1:0] x_pos [N_SLOTS];
	logic signed [COORD_W-1:0] y_pos [N_SLOTS];
	logic signed [COORD_W-1:0] z_pos [N_SLOTS];
	int cur_count = 0;
	int cos_q16 [QUARTER];
	int sin_q16 [QUARTER];

	sf_word_t pending_sums [$];

	int  mismatches = 0;
	int  loads_sent = 0, queries_sent = 0, sums_checked = 0, settings_used = 0;
	int  quiet_cycles = 0;
	int  hold_left = 0;
	bit  hold_req = 0, hold_taken = 0, calm = 0;

	// directed words; typed sums are read straight off the preloaded store
	row_t directed_rows [20] = '{
		'{0,   '{CMD_QUERY, 8'hA5, MAXC, MINC, 32'h1234_5678, MAXC, MINC, 32'h0F0F_0F0F},
			1, 0, 0},
		'{256, '{CMD_QUERY, 8'h00, 0, 0, 0, 0, 0, 0}, 1, SUM_LIMIT, 0},
		'{256, '{CMD_QUERY, 8'hFF, MINC, MINC, MINC, ONE, 0, 0}, 1, -SUM_LIMIT, 0},
		'{511, '{CMD_QUERY, 8'h00, 0, 0, 0, 0, 0, 0}, 1, SUM_LIMIT, 0},
		'{511, '{CMD_QUERY, 8'h00, 0, 0, 0, 0, ONE, 0}, 1, -SUM_LIMIT, 0},
		'{1,   '{CMD_QUERY, 8'h00, 0, 0, 0, 0, 0, HALF}, 1, 0, -65536},
		'{1,   '{CMD_QUERY, 8'h00, 0, 0, 0, 0, 0, 32'sh0180_0000}, 1, 0, 65536},
		'{1,   '{CMD_QUERY, 8'h00, 0, 0, 0, NEG1, 0, 0}, 1, -65536, 0},
		'{1,   '{CMD_LOAD, 8'h00, MAXC, MINC, 0, ONE, HALF, MAXC}, 0, 0, 0},
		'{1,   '{CMD_QUERY, 8'h00, 0, 0, 0, MAXC, MAXC, MAXC}, 0, 0, 0},
		'{1,   '{CMD_QUERY, 8'hFF, MAXC, MAXC, MAXC, MINC, MINC, MINC}, 0, 0, 0},
		'{256, '{CMD_LOAD, 8'hFF, MINC, MAXC, 32'hFFFF_FFFF, MINC, MINC, MINC}, 0, 0, 0},
		'{256, '{CMD_LOAD, 8'h80, 1, 32'hFFFF_FFFF, 32'h5555_5555, 0, 0, 0}, 0, 0, 0},
		'{256, '{CMD_QUERY, 8'h00, 0, 0, 0, 1, 32'hFFFF_FFFF, MAXC}, 0, 0, 0},
		'{256, '{CMD_QUERY, 8'h00, 0, 0, 0, ONE, ONE, ONE}, 0, 0, 0},
		'{2,   '{CMD_LOAD, 8'h01, 32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 0, 0, 0},
			0, 0, 0},
		'{2,   '{CMD_QUERY, 8'h00, 0, 0, 0, 1, 0, 0}, 0, 0, 0},
		'{2,   '{CMD_QUERY, 8'h00, 0, 0, 0, 32'h3333_3333, 32'h0040_0000, MINC}, 0, 0, 0},
		'{300, '{CMD_QUERY, 8'h00, 0, 0, 0, HALF, 32'h4000_0000, 32'hC000_0000}, 0, 0, 0},
		'{0,   '{CMD_QUERY, 8'h00, 0, 0, 0, MAXC, MAXC, MAXC}, 1, 0, 0}
	};

	structure_factor_phase_sum dut (.*);

	always #6 clk = ~clk;

	// (a * b) >> 60 on unsigned Q60 operands
	function automatic logic [63:0] fixmul60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	function automatic int q60_round16(input longint v);
		logic [63:0] u;
		if (v < 0)
			return 0;
		u = v;
		return int'((u + (64'd1 << 43)) >> 44);
	endfunction

	function automatic logic signed [OUT_W-1:0] clip_sum(input longint v);
		if (v > SUM_LIMIT)
			v = SUM_LIMIT;
		else if (v < -SUM_LIMIT)
			v = -SUM_LIMIT;
		return OUT_W'(v);
	endfunction

	// sum of cos(2 pi p) - i sin(2 pi p) over the summed atoms
	function automatic sf_word_t phase_sum(input logic signed [COORD_W-1:0] gx,
			input logic signed [COORD_W-1:0] gy, input logic signed [COORD_W-1:0] gz);
		longint      re_acc, im_acc, dot;
		logic [63:0] dot_bits;
		int          n, ph, quad, r, c, s;
		sf_word_t    w;
		re_acc = 0;
		im_acc = 0;
		n = (cur_count > N_SLOTS) ? N_SLOTS : cur_count;
		for (int a = 0; a < n; a++) begin
			dot = longint'(gx) * longint'(x_pos[a]) + longint'(gy) * longint'(y_pos[a])
				+ longint'(gz) * longint'(z_pos[a]);
			dot_bits = dot;
			ph = int'(dot_bits >> PH_SHIFT) & ((1 << PH_BITS) - 1);
			quad = ph >> (PH_BITS - 2);
			r = ph & (QUARTER - 1);
			// rotate the first-quadrant entry into place
			case (quad)
				0: begin
					c = cos_q16[r];
					s = sin_q16[r];
				end
				1: begin
					c = -sin_q16[r];
					s = cos_q16[r];
				end
				2: begin
					c = -cos_q16[r];
					s = -sin_q16[r];
				end
				default: begin
					c = sin_q16[r];
					s = -cos_q16[r];
				end
			endcase
			re_acc += c;
			im_acc -= s;
		end
		w.re = clip_sum(re_acc);
		w.im = clip_sum(im_acc);
		return w;
	endfunction

	// mostly full-range values, some on quarter-lattice steps to hit quadrant edges
	function automatic logic signed [COORD_W-1:0] rand_coord();
		logic signed [COORD_W-1:0] v;
		if ($urandom_range(99) < 30) begin
			v = $urandom_range(0, 16);
			return (v - 8) <<< 22;
		end
		return $urandom();
	endfunction

	// track an accepted word in the predictor
	task automatic absorb(input in_word_t w);
		if (w.cmd == CMD_LOAD) begin
			x_pos[w.slot] = w.px;
			y_pos[w.slot] = w.py;
			z_pos[w.slot] = w.pz;
			loads_sent++;
		end else begin
			pending_sums.push_back(phase_sum(w.gx, w.gy, w.gz));
			queries_sent++;
		end
	endtask

	// drive one word, with a random gap first, and hold it until accepted
	task automatic offer(input in_word_t w);
		int gap;
		gap = (!calm && $urandom_range(99) < 28) ? $urandom_range(1, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		cmd       = w.cmd;
		atom_slot = w.slot;
		pos_x     = w.px;
		pos_y     = w.py;
		pos_z     = w.pz;
		gvec_x    = w.gx;
		gvec_y    = w.gy;
		gvec_z    = w.gz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stop offering and wait for every outstanding sum, then let loads settle
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (LOAD_SETTLE) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [PDATA_W-1:0] wdata,
			output logic [PDATA_W-1:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {REG_ATOM_COUNT, 2'b00};
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic check_count_reg();
		logic [PDATA_W-1:0] rd;
		apb_xfer(1'b0, '0, rd);
		if (rd !== PDATA_W'(cur_count)) begin
			$error("atom_count readback: expected %0d, actual %0d", cur_count, rd);
			mismatches++;
		end
	endtask

	task automatic set_atom_count(input int value);
		logic [PDATA_W-1:0] rd;
		drain();
		apb_xfer(1'b1, PDATA_W'(value), rd);
		cur_count = value & ((1 << CNT_W) - 1);
		settings_used++;
		check_count_reg();
	endtask

	// build the first-quadrant table by Taylor series in Q60
	initial begin
		logic [63:0] step, x, x2, t;
		longint      acc;
		step = TWO_PI_Q60 >> PH_BITS;
		for (int k = 0; k < QUARTER; k++) begin
			x  = step * 64'(k);
			x2 = fixmul60(x, x);
			t   = x;
			acc = x;
			for (int n = 1; n < 40 && t != 0; n++) begin
				t = fixmul60(t, x2) / 64'((2 * n) * (2 * n + 1));
				acc = n[0] ? acc - longint'(t) : acc + longint'(t);
			end
			sin_q16[k] = q60_round16(acc);
			t   = 64'd1 << 60;
			acc = 64'd1 << 60;
			for (int n = 1; n < 40 && t != 0; n++) begin
				t = fixmul60(t, x2) / 64'((2 * n - 1) * (2 * n));
				acc = n[0] ? acc - longint'(t) : acc + longint'(t);
			end
			cos_q16[k] = q60_round16(acc);
		end
	end

	// receiver: random stalls, one long hold-off, no stalls in the calm stretch
	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall = 1'b1;
		end else if (calm) begin
			out_stall = 1'b0;
		end else begin
			out_stall = ($urandom_range(99) < 28);
		end
	end

	// compare each taken sum with the oldest expectation
	always @(posedge clk) begin
		sf_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				$error("sum word with no query outstanding: sf_real %0d sf_imag %0d",
					sf_real, sf_imag);
				mismatches++;
			end else begin
				want = pending_sums.pop_front();
				sums_checked++;
				if (sf_real !== want.re) begin
					$error("sf_real: expected %0d, actual %0d", want.re, sf_real);
					mismatches++;
				end
				if (sf_imag !== want.im) begin
					$error("sf_imag: expected %0d, actual %0d", want.im, sf_imag);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		in_word_t w;
		sf_word_t typed_sum;
		int       rand_idx, phase_len, pick;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		cmd       = CMD_LOAD;
		atom_slot = '0;
		pos_x     = '0;
		pos_y     = '0;
		pos_z     = '0;
		gvec_x    = '0;
		gvec_y    = '0;
		gvec_z    = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		check_count_reg();

		// preload every slot at (0.5, 0.5, 0.5) so no query reads an unwritten entry
		for (int s = 0; s < N_SLOTS; s++) begin
			w = '{CMD_LOAD, SLOT_W'(s), HALF, HALF, HALF, rand_coord(), rand_coord(),
				rand_coord()};
			offer(w);
			absorb(w);
		end

		// directed words
		foreach (directed_rows[i]) begin
			if (directed_rows[i].count != cur_count)
				set_atom_count(directed_rows[i].count);
			offer(directed_rows[i].w);
			if (directed_rows[i].typed) begin
				typed_sum.re = OUT_W'(directed_rows[i].want_re);
				typed_sum.im = OUT_W'(directed_rows[i].want_im);
				pending_sums.push_back(typed_sum);
				queries_sent++;
			end else begin
				absorb(directed_rows[i].w);
			end
		end

		// random phases, each with its own atom_count, mostly small
		rand_idx = 0;
		while (rand_idx < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 65)
				set_atom_count($urandom_range(0, 16));
			else if (pick < 85)
				set_atom_count($urandom_range(17, 64));
			else if (pick < 95)
				set_atom_count($urandom_range(200, 256));
			else
				set_atom_count($urandom_range(257, 511));
			phase_len = $urandom_range(20, 60);
			repeat (phase_len) begin
				calm = (rand_idx >= 1000 && rand_idx < 1300);
				w.cmd  = ($urandom_range(99) < 45) ? CMD_QUERY : CMD_LOAD;
				w.slot = ($urandom_range(99) < 60) ? SLOT_W'($urandom_range(0, 15))
					: SLOT_W'($urandom_range(0, 255));
				w.px   = rand_coord();
				w.py   = rand_coord();
				w.pz   = rand_coord();
				w.gx   = rand_coord();
				w.gy   = rand_coord();
				w.gz   = rand_coord();
				// ask for the long receiver hold-off once, on a query word
				if (rand_idx >= 300 && w.cmd == CMD_QUERY)
					hold_req = 1;
				offer(w);
				absorb(w);
				rand_idx++;
			end
		end
		calm = 0;

		drain();
		repeat (FINAL_SETTLE) @(posedge clk);
		if (pending_sums.size() != 0) begin
			$error("%0d sums never arrived", pending_sums.size());
			mismatches++;
		end
		$display("covered %0d loads and %0d queries, %0d sums checked, over %0d atom_count writes",
			loads_sent, queries_sent, sums_checked, settings_used);
		$display("including zero, full and over-range counts, saturation and a long output hold-off");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
